// ===== design/lcdv_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdv_pkg: shared types and constants for the line centroid Doppler velocity
// block. Sample and result payloads, the closed-profile job and status codes.
// ----------------------------------------------------------------------------
package lcdv_pkg;

  // Profile length bound and derived widths
  localparam int MAX_SAMPLES = 64;
  localparam int LOG_MAX     = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

  localparam int LAM_W  = 24;
  localparam int INT_W  = 16;
  localparam int PROD_W = LAM_W + INT_W;
  localparam int WLS_W  = LAM_W + LOG_MAX;
  localparam int ISUM_W = INT_W + LOG_MAX;
  localparam int WTD_W  = LAM_W + INT_W + LOG_MAX;

  localparam int VEL_W  = 30;
  localparam int STAT_W = 2;

  // Speed of light in m/s
  localparam int SOL_W = 29;
  localparam logic [SOL_W-1:0] SOL = 29'd299792458;
  localparam int DIV_IDX_W = $clog2(SOL_W);

  // Register reset values
  localparam logic [LAM_W-1:0] REST_RESET = 24'd6302500;
  localparam logic [INT_W-1:0] THR_RESET  = 16'd1000;

  // Status codes
  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_LOW      = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FLAT     = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_TOO_LONG = 2'd3;

  // Queue of closed profiles
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [LAM_W-1:0] wavelength;
    logic [INT_W-1:0] intensity;
    logic             last_sample;
  } sample_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] velocity;
    logic [STAT_W-1:0]       status;
  } result_t;

  // Sums of one closed profile
  typedef struct packed {
    logic [INT_W-1:0]  peak;
    logic [CNT_W-1:0]  count;
    logic [WLS_W-1:0]  wls;
    logic [ISUM_W-1:0] isum;
    logic [WTD_W-1:0]  wtd;
    logic              too_long;
  } job_t;

endpackage

// ===== design/line_centroid_doppler_velocity.sv =====
// ----------------------------------------------------------------------------
// line_centroid_doppler_velocity: centre-of-gravity Doppler velocity
// Accumulates one spectral line profile and returns its line-of-sight velocity.
//
//   port group        dir  handshake           payload
//   sample_*          in   valid / stall       sample_t (wavelength, intensity,
//                                              last_sample)
//   result_*          out  valid / stall       result_t (velocity, status)
//   p*                in   APB, pready high    rest_wavelength @0,
//                                              intensity_threshold @4
//
// Samples are taken one per cycle unless a closing sample waits on a full queue;
// closed profiles wait in a two-entry queue. The velocity unit takes a profile
// through a pop, five arithmetic steps, 29 division steps for the bits of C when
// the division is needed, and a hand-off, so short profiles stall the sample side
// once the queue is full. A stalled result holds the unit in its hand-off step.
// Synchronous reset clears all control state and restores the register reset values.
// ----------------------------------------------------------------------------
module line_centroid_doppler_velocity (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  lcdv_pkg::sample_t sample,
  output logic              result_valid,
  input  logic              result_stall,
  output lcdv_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic REG_REST = 1'b0;
  localparam logic REG_THR  = 1'b1;

  logic [lcdv_pkg::LAM_W-1:0] rest_wavelength;
  logic [lcdv_pkg::INT_W-1:0] intensity_threshold;

  logic           push, q_full, pop, q_valid;
  lcdv_pkg::job_t push_job, pop_job;

  assign pready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rest_wavelength     <= lcdv_pkg::REST_RESET;
      intensity_threshold <= lcdv_pkg::THR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_REST: rest_wavelength     <= pwdata[lcdv_pkg::LAM_W-1:0];
        REG_THR:  intensity_threshold <= pwdata[lcdv_pkg::INT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (paddr[2])
      REG_REST: prdata = 32'(rest_wavelength);
      REG_THR:  prdata = 32'(intensity_threshold);
      default:  prdata = '0;
    endcase
  end

  lcdv_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .push         (push),
    .q_full       (q_full),
    .job          (push_job)
  );

  lcdv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .pop_job  (pop_job)
  );

  lcdv_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .q_valid             (q_valid),
    .pop_job             (pop_job),
    .pop                 (pop),
    .rest_wavelength     (rest_wavelength),
    .intensity_threshold (intensity_threshold),
    .result_valid        (result_valid),
    .result_stall        (result_stall),
    .result              (result)
  );

endmodule

// ===== design/lcdv_front.sv =====
// ----------------------------------------------------------------------------
// lcdv_front: sample accumulator
// Registers each sample with its wavelength*intensity product, then folds it
// into the running peak and sums. The closing sample pushes a job to the queue.
// ----------------------------------------------------------------------------
module lcdv_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  lcdv_pkg::sample_t sample,
  output logic             push,
  input  logic             q_full,
  output lcdv_pkg::job_t   job
);

  // Sample stage
  logic                         s1_valid;
  logic [lcdv_pkg::LAM_W-1:0]   s1_lam;
  logic [lcdv_pkg::INT_W-1:0]   s1_int;
  logic [lcdv_pkg::PROD_W-1:0]  s1_prod;
  logic                         s1_last;
  logic                         s1_go;

  // Accumulators
  logic [lcdv_pkg::INT_W-1:0]   peak, peak_next;
  logic [lcdv_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic [lcdv_pkg::WLS_W-1:0]   wls, wls_next;
  logic [lcdv_pkg::ISUM_W-1:0]  isum, isum_next;
  logic [lcdv_pkg::WTD_W-1:0]   wtd, wtd_next;
  logic                         too_long, too_long_next;

  // Hold the closing sample while the queue is full
  assign s1_go        = !s1_last || !q_full;
  assign sample_stall = s1_valid && !s1_go;
  assign push         = s1_valid && s1_last && !q_full;

  // Fold the staged sample into the sums
  always_comb begin
    peak_next     = peak;
    cnt_next      = cnt;
    wls_next      = wls;
    isum_next     = isum;
    wtd_next      = wtd;
    too_long_next = too_long;
    if (cnt >= lcdv_pkg::CNT_W'(lcdv_pkg::MAX_SAMPLES)) begin
      too_long_next = 1'b1;
    end else begin
      if (cnt == '0 || s1_int > peak) begin
        peak_next = s1_int;
      end
      cnt_next  = cnt + 1'b1;
      wls_next  = wls + lcdv_pkg::WLS_W'(s1_lam);
      isum_next = isum + lcdv_pkg::ISUM_W'(s1_int);
      wtd_next  = wtd + lcdv_pkg::WTD_W'(s1_prod);
    end
  end

  assign job.peak     = peak_next;
  assign job.count    = cnt_next;
  assign job.wls      = wls_next;
  assign job.isum     = isum_next;
  assign job.wtd      = wtd_next;
  assign job.too_long = too_long_next;

  // Stage valid and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      peak     <= '0;
      cnt      <= '0;
      wls      <= '0;
      isum     <= '0;
      wtd      <= '0;
      too_long <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_valid && s1_go) begin
        if (s1_last) begin
          peak     <= '0;
          cnt      <= '0;
          wls      <= '0;
          isum     <= '0;
          wtd      <= '0;
          too_long <= 1'b0;
        end else begin
          peak     <= peak_next;
          cnt      <= cnt_next;
          wls      <= wls_next;
          isum     <= isum_next;
          wtd      <= wtd_next;
          too_long <= too_long_next;
        end
      end
    end
  end

  // Sample payload and product
  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      s1_lam  <= sample.wavelength;
      s1_int  <= sample.intensity;
      s1_last <= sample.last_sample;
      s1_prod <= lcdv_pkg::PROD_W'(sample.wavelength) * lcdv_pkg::PROD_W'(sample.intensity);
    end
  end

endmodule

// ===== design/lcdv_queue.sv =====
// ----------------------------------------------------------------------------
// lcdv_queue: short queue of closed profiles
// Decouples the sample accumulator from the velocity unit.
// ----------------------------------------------------------------------------
module lcdv_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lcdv_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output lcdv_pkg::job_t pop_job
);

  lcdv_pkg::job_t                entries [lcdv_pkg::QUEUE_DEPTH];
  logic [lcdv_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [lcdv_pkg::QCNT_W-1:0]   fill;

  assign full    = fill == lcdv_pkg::QCNT_W'(lcdv_pkg::QUEUE_DEPTH);
  assign q_valid = fill != '0;
  assign pop_job = entries[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== design/lcdv_back.sv =====
// ----------------------------------------------------------------------------
// lcdv_back: velocity unit
// Rebuilds weight and moment from the sums, classifies the profile and runs a
// radix-2 division of C*|moment - l0*weight| by l0*weight, one bit of C a step.
// ----------------------------------------------------------------------------
module lcdv_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  lcdv_pkg::job_t             pop_job,
  output logic                       pop,
  input  logic [lcdv_pkg::LAM_W-1:0] rest_wavelength,
  input  logic [lcdv_pkg::INT_W-1:0] intensity_threshold,
  output logic                       result_valid,
  input  logic                       result_stall,
  output lcdv_pkg::result_t          result
);

  localparam int PRD_W = lcdv_pkg::WTD_W;
  localparam int CP_W  = lcdv_pkg::CNT_W + lcdv_pkg::INT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUB  = 3'd2;
  localparam logic [2:0] ST_DEN  = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;
  localparam logic [2:0] ST_CHK  = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0] state;

  lcdv_pkg::job_t                                 jb;
  logic [CP_W-1:0]                                cp;
  logic [PRD_W-1:0]                               pw;
  logic [lcdv_pkg::ISUM_W-1:0]                    weight;
  logic [PRD_W-1:0]                               moment;
  logic [PRD_W-1:0]                               denom;
  logic [PRD_W-1:0]                               mag;
  logic                                           neg;
  logic [PRD_W-1:0]                               rem;
  logic [lcdv_pkg::SOL_W-1:0]                     quo;
  logic [lcdv_pkg::DIV_IDX_W-1:0]                 idx;
  logic [lcdv_pkg::STAT_W-1:0]                    fin_status;
  logic [lcdv_pkg::LAM_W-1:0]                     l0;

  // Division step
  logic [PRD_W+1:0]   t, t_one, t_two;
  logic [PRD_W+1:0]   den_one, den_two;
  logic [PRD_W-1:0]   rem_next;
  logic [1:0]         digit;
  logic [lcdv_pkg::VEL_W-1:0] vel_mag;

  logic out_free;

  assign l0       = (rest_wavelength == '0) ? lcdv_pkg::LAM_W'(1) : rest_wavelength;
  assign pop      = (state == ST_IDLE) && q_valid;
  assign out_free = !result_valid || !result_stall;

  // Partial remainder and quotient digit
  always_comb begin
    den_one = {2'b00, denom};
    den_two = {1'b0, denom, 1'b0};
    t       = {1'b0, rem, 1'b0} + (lcdv_pkg::SOL[idx] ? {2'b00, mag} : '0);
    t_one   = t - den_one;
    t_two   = t - den_two;
    priority if (t >= den_two) begin
      digit    = 2'd2;
      rem_next = t_two[PRD_W-1:0];
    end else if (t >= den_one) begin
      digit    = 2'd1;
      rem_next = t_one[PRD_W-1:0];
    end else begin
      digit    = 2'd0;
      rem_next = t[PRD_W-1:0];
    end
  end

  assign vel_mag = {1'b0, quo};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      // Raise valid at hand-off, drop it once the result is taken
      if (state == ST_FIN && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: state <= ST_SUB;
        ST_SUB: state <= ST_DEN;
        ST_DEN: state <= ST_CMP;
        ST_CMP: state <= ST_CHK;
        ST_CHK: begin
          if (!jb.too_long && jb.peak > intensity_threshold && weight != '0 && mag < denom) begin
            state <= ST_DIV;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_DIV: begin
          if (idx == '0) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        jb <= pop_job;
      end
      ST_MUL: begin
        cp <= CP_W'(jb.count) * CP_W'(jb.peak);
        pw <= PRD_W'(jb.peak) * PRD_W'(jb.wls);
      end
      ST_SUB: begin
        weight <= lcdv_pkg::ISUM_W'(cp - CP_W'(jb.isum));
        moment <= pw - jb.wtd;
      end
      ST_DEN: begin
        denom <= PRD_W'(l0) * PRD_W'(weight);
      end
      ST_CMP: begin
        neg <= moment < denom;
        mag <= (moment < denom) ? denom - moment : moment - denom;
      end
      ST_CHK: begin
        rem <= '0;
        quo <= '0;
        idx <= lcdv_pkg::DIV_IDX_W'(lcdv_pkg::SOL_W - 1);
        priority if (jb.too_long) begin
          fin_status <= lcdv_pkg::STATUS_TOO_LONG;
        end else if (jb.peak <= intensity_threshold) begin
          fin_status <= lcdv_pkg::STATUS_LOW;
        end else if (weight == '0) begin
          fin_status <= lcdv_pkg::STATUS_FLAT;
        end else begin
          fin_status <= lcdv_pkg::STATUS_OK;
          if (mag >= denom) begin
            quo <= lcdv_pkg::SOL;
          end
        end
      end
      ST_DIV: begin
        rem <= rem_next;
        quo <= lcdv_pkg::SOL_W'({quo, 1'b0} + (lcdv_pkg::SOL_W + 1)'(digit));
        idx <= idx - 1'b1;
      end
      ST_FIN: begin
        if (out_free) begin
          result.status <= fin_status;
          if (fin_status != lcdv_pkg::STATUS_OK) begin
            result.velocity <= '0;
          end else if (neg) begin
            result.velocity <= -$signed(vel_mag);
          end else begin
            result.velocity <= $signed(vel_mag);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: line centroid Doppler velocity
// Streams spectral profiles into the block and checks every velocity and status
// against a cycle-free predictor of the centroid arithmetic, or for typed
// directed rows against the result in the table. A directed table covers the
// extremes and special profiles. Random profiles then run over several register
// settings, with random idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdv_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 100;
  localparam int MAX_REPORTS    = 10;

  localparam logic [2:0] REG_REST = 3'd0;
  localparam logic [2:0] REG_THR  = 3'd4;

  localparam logic signed [VEL_W-1:0] VEL_MAX = 30'sd299792458;
  localparam logic signed [VEL_W-1:0] VEL_MIN = -30'sd299792458;

  // Register settings per phase; a rest of -1 picks a random value
  localparam int PHASES = 7;
  localparam int PH_REST [PHASES] = '{6302500, 16777215, 1, 0, 5000000, -1, 6302500};
  localparam int PH_THR  [PHASES] = '{1000, 0, 65535, 500, 30000, -1, 1000};
  localparam int PH_TX   [PHASES] = '{0, 76, 0, 32, 0, 76, 0};
  localparam int PH_RX   [PHASES] = '{0, 0, 76, 32, 32, 76, 0};
  localparam int PH_HOLD [PHASES] = '{0, 0, 0, 0, 1, 0, 0};
  localparam int PH_ITEMS[PHASES] = '{100, 330, 200, 300, 330, 350, 200};

  typedef struct packed {
    logic [LAM_W-1:0] lam;
    logic [INT_W-1:0] inten;
    logic             last;
    logic [7:0]       reps;
    logic             typed;
    result_t          res;
  } dir_row_t;

  // Directed profiles; typed rows carry their expected result
  localparam int DIR_ROWS = 22;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{24'd6302500, 16'd5000,  1'b1, 8'd1,  1'b1, '{30'sd0, STATUS_FLAT}},
    '{24'd0,       16'd0,     1'b1, 8'd1,  1'b1, '{30'sd0, STATUS_LOW}},
    '{24'hFFFFFF,  16'hFFFF,  1'b1, 8'd1,  1'b1, '{30'sd0, STATUS_FLAT}},
    '{24'd100,     16'd1000,  1'b0, 8'd1,  1'b0, '{30'sd0, STATUS_OK}},
    '{24'd200,     16'd1000,  1'b1, 8'd1,  1'b1, '{30'sd0, STATUS_LOW}},
    '{24'd12605000, 16'd0,    1'b0, 8'd1,  1'b0, '{30'sd0, STATUS_OK}},
    '{24'd0,       16'd5000,  1'b1, 8'd1,  1'b1, '{VEL_MAX, STATUS_OK}},
    '{24'd0,       16'd0,     1'b0, 8'd1,  1'b0, '{30'sd0, STATUS_OK}},
    '{24'hFFFFFF,  16'd5000,  1'b1, 8'd1,  1'b1, '{VEL_MIN, STATUS_OK}},
    '{24'd6302500, 16'd0,     1'b0, 8'd1,  1'b0, '{30'sd0, STATUS_OK}},
    '{24'd1234,    16'd5000,  1'b1, 8'd1,  1'b1, '{30'sd0, STATUS_OK}},
    '{24'd6302000, 16'd3000,  1'b1, 8'd3,  1'b1, '{30'sd0, STATUS_FLAT}},
    '{24'd6302500, 16'd4000,  1'b1, 8'd65, 1'b1, '{30'sd0, STATUS_TOO_LONG}},
    '{24'd6302400, 16'd2000,  1'b0, 8'd63, 1'b0, '{30'sd0, STATUS_OK}},
    '{24'd6302600, 16'd0,     1'b1, 8'd1,  1'b0, '{30'sd0, STATUS_OK}},
    '{24'd6302500, 16'd1001,  1'b0, 8'd1,  1'b0, '{30'sd0, STATUS_OK}},
    '{24'd6302700, 16'd0,     1'b1, 8'd1,  1'b0, '{30'sd0, STATUS_OK}},
    '{24'hFFFFFF,  16'd0,     1'b0, 8'd1,  1'b0, '{30'sd0, STATUS_OK}},
    '{24'd0,       16'hFFFF,  1'b1, 8'd1,  1'b0, '{30'sd0, STATUS_OK}},
    '{24'd6301000, 16'd20000, 1'b0, 8'd1,  1'b0, '{30'sd0, STATUS_OK}},
    '{24'd6302000, 16'd100,   1'b0, 8'd1,  1'b0, '{30'sd0, STATUS_OK}},
    '{24'd6303500, 16'd40000, 1'b1, 8'd1,  1'b0, '{30'sd0, STATUS_OK}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  sample_t     sample = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor copy of the registers and the running profile sums
  logic [LAM_W-1:0]  rest_cfg = REST_RESET;
  logic [INT_W-1:0]  thr_cfg  = THR_RESET;
  logic [INT_W-1:0]  acc_peak = '0;
  logic [CNT_W-1:0]  acc_count = '0;
  logic [WLS_W-1:0]  acc_wls = '0;
  logic [ISUM_W-1:0] acc_isum = '0;
  logic [WTD_W-1:0]  acc_wtd = '0;
  logic              acc_overflow = 1'b0;

  result_t awaited_results [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int phase_samples = 0;
  int total_samples = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  line_centroid_doppler_velocity uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Fold one sample into the profile sums; on the closing sample work out
  // the centroid velocity and clear the sums
  function automatic bit fold_sample(input sample_t s, output result_t r);
    logic [63:0]  weight;
    logic [63:0]  moment;
    logic [63:0]  denom;
    logic [63:0]  mag;
    logic [63:0]  l0;
    logic [63:0]  v;
    logic [127:0] scaled;
    bit           neg;
    r = '0;
    if (acc_count >= MAX_SAMPLES) begin
      acc_overflow = 1'b1;
    end else begin
      if (acc_count == 0 || s.intensity > acc_peak) acc_peak = s.intensity;
      acc_count = acc_count + 1'b1;
      acc_wls   = acc_wls + WLS_W'(s.wavelength);
      acc_isum  = acc_isum + ISUM_W'(s.intensity);
      acc_wtd   = acc_wtd + WTD_W'(s.wavelength) * WTD_W'(s.intensity);
    end
    if (!s.last_sample) return 1'b0;
    if (acc_overflow) begin
      r.status = STATUS_TOO_LONG;
    end else if (acc_peak <= thr_cfg) begin
      r.status = STATUS_LOW;
    end else begin
      weight = 64'(acc_count) * 64'(acc_peak) - 64'(acc_isum);
      if (weight == 0) begin
        r.status = STATUS_FLAT;
      end else begin
        // A zero rest wavelength counts as one
        l0     = (rest_cfg == 0) ? 64'd1 : 64'(rest_cfg);
        moment = 64'(acc_peak) * 64'(acc_wls) - 64'(acc_wtd);
        denom  = l0 * weight;
        neg    = moment < denom;
        mag    = neg ? denom - moment : moment - denom;
        if (mag >= denom) begin
          v = 64'(SOL);
        end else begin
          scaled = (128'(SOL) * 128'(mag)) / 128'(denom);
          v = scaled[63:0];
        end
        if (neg) v = 64'd0 - v;
        r.velocity = v[VEL_W-1:0];
        r.status   = STATUS_OK;
      end
    end
    acc_peak     = '0;
    acc_count    = '0;
    acc_wls      = '0;
    acc_isum     = '0;
    acc_wtd      = '0;
    acc_overflow = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [LAM_W-1:0] clamp_lam(input int v);
    if (v < 0) return '0;
    if (v > 24'hFFFFFF) return 24'hFFFFFF;
    return v[LAM_W-1:0];
  endfunction

  // Offer one sample, wait for it to be taken, then idle at random
  task automatic send_sample(input sample_t s, input bit typed, input result_t typed_res);
    result_t r;
    sample       <= s;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    if (fold_sample(s, r)) awaited_results.push_back(typed ? typed_res : r);
    phase_samples++;
    total_samples++;
    while ($urandom_range(99) < idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Random profile: mostly a line near the rest wavelength, with flat, weak,
  // wild and over-long profiles mixed in
  task automatic send_profile();
    int      len;
    int      kind;
    int      shift;
    int      pick;
    sample_t s;
    logic [INT_W-1:0] flat_level;
    pick = $urandom_range(99);
    if (pick < 4)       len = $urandom_range(MAX_SAMPLES + 1, MAX_SAMPLES + 6);
    else if (pick < 9)  len = $urandom_range(13, MAX_SAMPLES);
    else                len = $urandom_range(1, 12);
    kind       = $urandom_range(99);
    shift      = $urandom_range(6000) - 3000;
    flat_level = INT_W'($urandom);
    for (int k = 0; k < len; k++) begin
      if (kind < 70) begin
        s.wavelength = clamp_lam(int'(rest_cfg) + shift + $urandom_range(8000) - 4000);
        s.intensity  = INT_W'($urandom);
      end else if (kind < 80) begin
        s.wavelength = clamp_lam(int'(rest_cfg) + shift + $urandom_range(8000) - 4000);
        s.intensity  = flat_level;
      end else if (kind < 90) begin
        s.wavelength = clamp_lam(int'(rest_cfg) + $urandom_range(2000) - 1000);
        s.intensity  = INT_W'($urandom_range(2000));
      end else begin
        s.wavelength = LAM_W'($urandom);
        s.intensity  = INT_W'($urandom);
      end
      s.last_sample = (k == len - 1);
      send_sample(s, 1'b0, '0);
    end
  endtask

  // Drop valid and wait until every awaited result is in, then let the
  // unit drain
  task automatic settle();
    sample_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write then read back
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data,
                           input logic [31:0] mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if ((prdata & mask) !== (data & mask)) begin
      if (errors < MAX_REPORTS)
        $display("Register %0d read back %0h, expected %0h", addr, prdata & mask, data & mask);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver: random stall, or a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Check each result against the oldest prediction; watch for a hang
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        status_seen[result.status]++;
        if (awaited_results.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("Unexpected result: velocity %0d status %0d", result.velocity,
                     result.status);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (result.velocity !== want.velocity || result.status !== want.status) begin
            if (errors < MAX_REPORTS)
              $display("Mismatch: velocity %0d status %0d, expected velocity %0d status %0d",
                       result.velocity, result.status, want.velocity, want.status);
            errors++;
          end
        end
      end
      if ((result_valid && !result_stall) || (sample_valid && !sample_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    sample_t          s;
    logic [LAM_W-1:0] rest_val;
    logic [INT_W-1:0] thr_val;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < PHASES; ph++) begin
      // Registers change only with the block idle
      if (ph > 0) begin
        settle();
        rest_val = (PH_REST[ph] < 0) ? LAM_W'($urandom_range(1, 24'hFFFFFF))
                                     : LAM_W'(PH_REST[ph]);
        thr_val  = (PH_THR[ph] < 0) ? INT_W'($urandom_range(0, 20000))
                                    : INT_W'(PH_THR[ph]);
        write_reg(REG_REST, 32'(rest_val), 32'hFFFFFF);
        write_reg(REG_THR, 32'(thr_val), 32'hFFFF);
        rest_cfg = rest_val;
        thr_cfg  = thr_val;
      end
      idle_pct      = PH_TX[ph];
      stall_pct     = PH_RX[ph];
      phase_samples = 0;
      if (PH_HOLD[ph] != 0) hold_requests <= hold_requests + 1;
      if (ph == 0) begin
        // Walk the directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
          for (int k = 0; k < DIR_TABLE[i].reps; k++) begin
            s.wavelength  = DIR_TABLE[i].lam;
            s.intensity   = DIR_TABLE[i].inten;
            s.last_sample = DIR_TABLE[i].last && (k == DIR_TABLE[i].reps - 1);
            send_sample(s, DIR_TABLE[i].typed && s.last_sample, DIR_TABLE[i].res);
          end
        end
        phase_samples = 0;
      end
      while (phase_samples < PH_ITEMS[ph]) send_profile();
    end
    settle();
    if (awaited_results.size() != 0) begin
      $display("%0d results never arrived", awaited_results.size());
      errors++;
    end
    $display("Ran %0d samples over %0d register settings; results: %0d ok, %0d below threshold,",
             total_samples, PHASES, status_seen[STATUS_OK], status_seen[STATUS_LOW]);
    $display("  %0d flat, %0d too long; %0d mismatches", status_seen[STATUS_FLAT],
             status_seen[STATUS_TOO_LONG], errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== line_centroid_doppler_velocity.f =====
design/lcdv_pkg.sv
design/lcdv_front.sv
design/lcdv_queue.sv
design/lcdv_back.sv
design/line_centroid_doppler_velocity.sv
verif/testbench.sv
